FILE: hw/rtl/pidsa_pkg.sv
// Package: shared types and constants for the PID servo angle controller.
`default_nettype none
package pidsa_pkg;
	localparam int GainW = 24;
	localparam int PosW = 16;
	localparam int TimeW = 32;
	localparam int IntW = 40;
	localparam int AngleW = 8;
	// width of a gain times a position difference (24 + 17)
	localparam int ProdW = 41;

	localparam logic [1:0] REG_GAIN_P = 2'd0;
	localparam logic [1:0] REG_GAIN_I = 2'd1;
	localparam logic [1:0] REG_GAIN_D = 2'd2;

	localparam logic signed [GainW-1:0] GAIN_P_RESET = 24'sd256;
	localparam logic signed [PosW-1:0] POS_EDGE = 16'sd135;
	localparam logic signed [IntW-1:0] INT_MAX = {1'b0, {(IntW-1){1'b1}}};
	localparam logic signed [IntW-1:0] INT_MIN = {1'b1, {(IntW-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SUM,
		ST_OUT
	} state_t;

	// start request and result flags between the top level and the multiplier
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} seq_ctl_t;
endpackage
`default_nettype wire

FILE: hw/rtl/pidsa_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle.
`default_nettype none
module pidsa_mul
	import pidsa_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [GainW-1:0] mcand,
	input  wire logic signed [PosW:0]    mplier,
	output seq_ctl_t                     ctl,
	output logic signed [ProdW-1:0]      product
);
	localparam int CntW = $clog2(PosW + 2);

	logic [CntW-1:0] cnt_q;
	logic busy_q, done_q;
	logic signed [ProdW-1:0] acc_q;
	logic signed [ProdW-1:0] mc_q;
	logic [PosW:0] mp_q;
	logic signed [ProdW-1:0] addend;

	// top multiplier bit carries negative weight
	always_comb begin
		addend = mp_q[0] ? mc_q : '0;
		if (cnt_q == CntW'(PosW)) addend = -addend;
	end

	// shift one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(PosW)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q <= ProdW'(mcand);
			mp_q <= mplier;
		end else if (busy_q) begin
			acc_q <= acc_q + addend;
			mc_q <= mc_q <<< 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign ctl.done = done_q;
	assign product = acc_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without busy");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q)) else $error("busy and done together");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= CntW'(PosW)) else $error("count overrun");
endmodule
`default_nettype wire

FILE: hw/rtl/pid_servo_angle_controller.sv
// Top level: PID servo angle controller with clamped output.
// Usage:
// - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes gain_p (0),
//   gain_i (1), gain_d (2), signed Q.8; other indexes are dropped. Write only
//   while idle.
// - Input channel (in_valid/in_ready) takes position and time_ms; output channel
//   (out_valid/out_ready) returns servo_angle 0..180.
// - One sample at a time: the bit-serial multiplier forms the P, I and D
//   products, the restoring divider then divides the D product by the time step
//   (one quotient bit per cycle; skipped when time_ms did not change), and a
//   sum step and a clamp step follow; out_valid rises after the clamp step.
//   A new sample is taken only once the previous result has drained.
// - A sample resting at 135 twice clears the integral and gives no result;
//   the block stays idle and the next sample can follow at once.
// - Result sits in an output register; a stalled receiver holds it and the
//   block takes no new sample until it drains.
// - Reset: gains to 1.0/0/0, integral, last position and last time to zero.
`default_nettype none
module pid_servo_angle_controller
	import pidsa_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [GainW-1:0]        cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [PosW-1:0]  position,
	input  wire logic [TimeW-1:0]        time_ms,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [AngleW-1:0]            servo_angle
);
	localparam int DivW = ProdW;
	localparam int DCntW = $clog2(DivW + 1);
	localparam int SumW = IntW + 4;

	state_t state_q, state_d;
	logic [1:0] phase_q;
	logic signed [GainW-1:0] gp_q, gi_q, gd_q;
	logic signed [IntW-1:0] integ_q;
	logic signed [PosW-1:0] prev_pos_q;
	logic signed [PosW:0] dpos_q;
	logic [TimeW-1:0] prev_time_q, dt_q;
	logic signed [PosW:0] mapped_q;
	logic signed [ProdW-1:0] p_q;
	logic signed [SumW-1:0] d_q;
	logic [AngleW-1:0] angle_q;
	logic out_valid_q;

	// divider state
	logic [DivW-1:0] quo_q;
	logic [TimeW:0] rem_q;
	logic [DCntW-1:0] dcnt_q;
	logic dneg_q;

	logic mul_start;
	logic signed [GainW-1:0] mul_a;
	logic signed [PosW:0] mul_b;
	seq_ctl_t mctl;
	logic signed [ProdW-1:0] mprod;

	logic accept, rest;
	logic signed [PosW+8:0] num;
	logic signed [PosW+8:0] mq;
	logic signed [IntW+1:0] isum;
	logic signed [SumW-1:0] total;
	logic [TimeW:0] rtry;

	assign accept = in_valid && in_ready;
	assign rest = (position == POS_EDGE) && (prev_pos_q == POS_EDGE);
	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign servo_angle = angle_q;

	// map: (x+135)*180/270-90 = (x+135)*2/3 - 90 truncated; numerator >= 0 in range
	// except negative, so divide magnitude by 3 with a reciprocal multiply
	always_comb begin
		logic [PosW+8:0] mag;
		logic [PosW+8+22:0] prodr;
		logic [PosW+8:0] qq;
		num = ((PosW+9)'(position) + (PosW+9)'(135)) <<< 1;
		mag = num[PosW+8] ? -num : num;
		prodr = (PosW+8+23)'(mag) * (PosW+8+23)'(22'd1398102);
		qq = prodr[PosW+8+22:22];
		if ((PosW+9)'(qq * 3) > mag) qq = qq - 1'b1;
		mq = num[PosW+8] ? -$signed(qq) : $signed(qq);
	end

	// multiplier operand select
	always_comb begin
		mul_a = gp_q;
		mul_b = mapped_q;
		unique case (phase_q)
			2'd0: mul_a = gp_q;
			2'd1: mul_a = gi_q;
			default: begin
				mul_a = gd_q;
				mul_b = dpos_q;
			end
		endcase
	end

	assign mul_start = (state_q == ST_MUL) && !mctl.busy && !mctl.done && (dcnt_q == '0)
		&& !phase_q[1] | ((state_q == ST_MUL) && phase_q == 2'd2 && !mctl.busy
		&& !mctl.done && dcnt_q == '0);

	pidsa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mul_a),
		.mplier (mul_b),
		.ctl    (mctl),
		.product(mprod)
	);

	assign isum = (IntW+2)'(integ_q) + (IntW+2)'(mprod);
	assign rtry = {rem_q[TimeW-1:0], quo_q[DivW-1]} - {1'b0, dt_q};
	assign total = (SumW)'(p_q) + (SumW)'(integ_q) + d_q + (SumW)'(90 * 256);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && !rest) state_d = ST_MUL;
			ST_MUL: if (mctl.done && phase_q == 2'd2)
				state_d = (dt_q == '0) ? ST_SUM : ST_DIV;
			ST_DIV: if (dcnt_q == DCntW'(1)) state_d = ST_SUM;
			ST_SUM: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			out_valid_q <= 1'b0;
			gp_q <= GAIN_P_RESET;
			gi_q <= '0;
			gd_q <= '0;
			integ_q <= '0;
			prev_pos_q <= '0;
			prev_time_q <= '0;
			dcnt_q <= '0;
		end else begin
			state_q <= state_d;
			// config writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_GAIN_P: gp_q <= cfg_data;
					REG_GAIN_I: gi_q <= cfg_data;
					REG_GAIN_D: gd_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (accept) begin
				phase_q <= '0;
				if (rest) integ_q <= '0;
				else begin
					prev_pos_q <= position;
					prev_time_q <= time_ms;
				end
			end
			// integral update after the I product
			if (state_q == ST_MUL && mctl.done) begin
				phase_q <= phase_q + 1'b1;
				if (phase_q == 2'd1) begin
					if (isum > (IntW+2)'(INT_MAX)) integ_q <= INT_MAX;
					else if (isum < (IntW+2)'(INT_MIN)) integ_q <= INT_MIN;
					else integ_q <= IntW'(isum);
				end
				if (phase_q == 2'd2 && dt_q != '0) dcnt_q <= DCntW'(DivW);
			end
			if (state_q == ST_DIV) dcnt_q <= dcnt_q - 1'b1;
			if (state_q == ST_OUT) out_valid_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			dpos_q <= (PosW+1)'(position) - (PosW+1)'(prev_pos_q);
			mapped_q <= (PosW+1)'(mq - (PosW+9)'(90));
			dt_q <= time_ms - prev_time_q;
			d_q <= '0;
		end
		if (state_q == ST_MUL && mctl.done) begin
			if (phase_q == 2'd0) p_q <= mprod;
			if (phase_q == 2'd2) begin
				dneg_q <= mprod[ProdW-1];
				quo_q <= mprod[ProdW-1] ? DivW'(-mprod) : DivW'(mprod);
				rem_q <= '0;
			end
		end
		// restoring division, one quotient bit per cycle
		if (state_q == ST_DIV) begin
			if (!rtry[TimeW]) begin
				rem_q <= rtry;
				quo_q <= {quo_q[DivW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[TimeW-1:0], quo_q[DivW-1]};
				quo_q <= {quo_q[DivW-2:0], 1'b0};
			end
		end
		if (state_q == ST_SUM && dt_q != '0)
			d_q <= dneg_q ? -(SumW'(quo_q)) : SumW'(quo_q);
		if (state_q == ST_OUT) begin
			if (total >= SumW'(180 * 256)) angle_q <= AngleW'(180);
			else if (total < 0) angle_q <= '0;
			else angle_q <= total[AngleW+7:8];
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == ST_IDLE) else $error("accept while busy");
	a_out_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT) else $error("stray result");
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> angle_q <= AngleW'(180)) else $error("angle out of range");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> dt_q != '0) else $error("divide by zero");
endmodule
`default_nettype wire
